/* sv/dsti_pkg.sv */
// ----------------------------------------------------------------------------
// dsti_pkg
// Shared constants and stage types of the decimal string to integer unit.
// ----------------------------------------------------------------------------
package dsti_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAG_WIDTH   = 64;
  localparam int CH_WIDTH    = 8;
  localparam int DIGIT_WIDTH = 4;

  localparam logic [MAG_WIDTH-1:0] POS_LIMIT =
    (MAG_WIDTH'(1) << (VALUE_WIDTH - 1)) - MAG_WIDTH'(1);
  localparam logic [MAG_WIDTH-1:0] NEG_LIMIT = POS_LIMIT + MAG_WIDTH'(1);

  localparam logic [CH_WIDTH-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CH_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CH_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CH_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CH_WIDTH-1:0] DIGIT_MAX  = 8'd9;

  localparam int CFG_ADDR_WIDTH = 4;
  localparam int CFG_DATA_WIDTH = 64;

  localparam logic REG_MIN_VALUE = 1'b0;
  localparam logic REG_MAX_VALUE = 1'b1;

  typedef struct packed {
    logic [MAG_WIDTH-1:0] magnitude;
    logic                 negative;
    logic                 failed;
    logic                 digit_seen;
  } dsti_end_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   good;
  } dsti_fin_t;

endpackage

/* sv/dsti_cfg.sv */
// ----------------------------------------------------------------------------
// dsti_cfg
// Bound registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module dsti_cfg import dsti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output logic [VALUE_WIDTH-1:0]    min_value,
  output logic [VALUE_WIDTH-1:0]    max_value
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value <= NEG_LIMIT;
      max_value <= POS_LIMIT;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MIN_VALUE: min_value <= pwdata;
        REG_MAX_VALUE: max_value <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_VALUE: prdata = min_value;
      REG_MAX_VALUE: prdata = max_value;
      default:       prdata = '0;
    endcase
  end

endmodule

/* sv/dsti_parse.sv */
// ----------------------------------------------------------------------------
// dsti_parse
// Input register and character parser; hands the final parse state of each
// string to the next stage when the terminating NUL arrives.
// ----------------------------------------------------------------------------
module dsti_parse import dsti_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [CH_WIDTH-1:0] s_tdata,
  output dsti_end_t           end_word,
  output logic                end_valid,
  input  logic                end_ready
);

  logic                   in_valid;
  logic [CH_WIDTH-1:0]    ch_q;
  logic                   consume;
  logic                   end_load;
  logic                   end_room;

  logic [MAG_WIDTH-1:0]   magnitude, magnitude_next;
  logic                   negative, negative_next;
  logic                   at_start, at_start_next;
  logic                   digit_seen, digit_seen_next;
  logic                   lead_zero, lead_zero_next;
  logic                   failed, failed_next;

  logic [CH_WIDTH-1:0]    ch_off;
  logic                   is_digit;
  logic [DIGIT_WIDTH-1:0] digit;
  logic [MAG_WIDTH+3:0]   mag_ext;
  logic [MAG_WIDTH+3:0]   prod;
  logic                   ovf;

  assign end_room = !end_valid || end_ready;
  assign consume  = in_valid && ((ch_q != CHAR_NUL) || end_room);
  assign end_load = consume && (ch_q == CHAR_NUL);
  assign s_tready = !in_valid || consume;

  assign ch_off   = ch_q - CHAR_ZERO;
  assign is_digit = (ch_q >= CHAR_ZERO) && (ch_off <= DIGIT_MAX);
  assign digit    = ch_off[DIGIT_WIDTH-1:0];
  assign mag_ext  = {4'b0, magnitude};
  assign prod     = (mag_ext << 3) + (mag_ext << 1) + {{MAG_WIDTH{1'b0}}, digit};
  assign ovf      = |prod[MAG_WIDTH+3:MAG_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ch_q <= s_tdata;
    end
  end

  always_comb begin
    magnitude_next  = magnitude;
    negative_next   = negative;
    at_start_next   = at_start;
    digit_seen_next = digit_seen;
    lead_zero_next  = lead_zero;
    failed_next     = failed;
    if (end_load) begin
      magnitude_next  = '0;
      negative_next   = 1'b0;
      at_start_next   = 1'b1;
      digit_seen_next = 1'b0;
      lead_zero_next  = 1'b0;
      failed_next     = 1'b0;
    end else if (consume && !failed) begin
      at_start_next = 1'b0;
      if (at_start && (ch_q == CHAR_PLUS)) begin
        at_start_next = 1'b0;
      end else if (at_start && (ch_q == CHAR_MINUS)) begin
        negative_next = 1'b1;
      end else if (lead_zero || !is_digit) begin
        failed_next = 1'b1;
      end else begin
        if (!digit_seen && (digit == '0)) begin
          lead_zero_next = 1'b1;
        end
        digit_seen_next = 1'b1;
        if (ovf) begin
          failed_next = 1'b1;
        end else begin
          magnitude_next = prod[MAG_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude  <= '0;
      negative   <= 1'b0;
      at_start   <= 1'b1;
      digit_seen <= 1'b0;
      lead_zero  <= 1'b0;
      failed     <= 1'b0;
    end else begin
      magnitude  <= magnitude_next;
      negative   <= negative_next;
      at_start   <= at_start_next;
      digit_seen <= digit_seen_next;
      lead_zero  <= lead_zero_next;
      failed     <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_valid <= 1'b0;
    end else if (end_load) begin
      end_valid <= 1'b1;
    end else if (end_ready) begin
      end_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_load) begin
      end_word.magnitude  <= magnitude;
      end_word.negative   <= negative;
      end_word.failed     <= failed;
      end_word.digit_seen <= digit_seen;
    end
  end

endmodule

/* sv/dsti_finish.sv */
// ----------------------------------------------------------------------------
// dsti_finish
// Applies the sign to the parsed magnitude and checks the signed limits.
// ----------------------------------------------------------------------------
module dsti_finish import dsti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dsti_end_t end_word,
  input  logic      end_valid,
  output logic      end_ready,
  output dsti_fin_t fin_word,
  output logic      fin_valid,
  input  logic      fin_ready
);

  logic                   load;
  logic                   in_limit;
  logic [VALUE_WIDTH-1:0] neg_value;

  assign end_ready = !fin_valid || fin_ready;
  assign load      = end_valid && end_ready;
  assign neg_value = VALUE_WIDTH'(~end_word.magnitude + MAG_WIDTH'(1));
  assign in_limit  = end_word.negative ? (end_word.magnitude <= NEG_LIMIT)
                                       : (end_word.magnitude <= POS_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (load) begin
      fin_valid <= 1'b1;
    end else if (fin_ready) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fin_word.value <= end_word.negative ? neg_value
                                          : VALUE_WIDTH'(end_word.magnitude);
      fin_word.good  <= !end_word.failed && end_word.digit_seen && in_limit;
    end
  end

endmodule

/* sv/dsti_bound.sv */
// ----------------------------------------------------------------------------
// dsti_bound
// Checks the signed value against the configured bounds and holds the result
// word in the output register.
// ----------------------------------------------------------------------------
module dsti_bound import dsti_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dsti_fin_t              fin_word,
  input  logic                   fin_valid,
  output logic                   fin_ready,
  input  logic [VALUE_WIDTH-1:0] min_value,
  input  logic [VALUE_WIDTH-1:0] max_value,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [VALUE_WIDTH-1:0] m_tdata,
  output logic [0:0]             m_tuser
);

  logic load;
  logic below;
  logic above;
  logic ok;

  assign fin_ready = !m_tvalid || m_tready;
  assign load      = fin_valid && fin_ready;
  assign below     = $signed(fin_word.value) < $signed(min_value);
  assign above     = $signed(max_value) < $signed(fin_word.value);
  assign ok        = fin_word.good && !below && !above;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= ok ? fin_word.value : '0;
      m_tuser[0] <= ok;
    end
  end

endmodule

/* sv/decimal_string_to_int_range_check_unit.sv */
// ----------------------------------------------------------------------------
// decimal_string_to_int_range_check_unit
// Parses a NUL-terminated signed decimal string, one byte per word, and
// returns the value with a range check against programmable bounds.
// ----------------------------------------------------------------------------
//  channel   direction  word contents
//  s_axis    in         tdata[7:0] = ch
//  m_axis    out        tdata[63:0] = value, tuser[0] = ok
//  apb       in/out     0x0 = min_value, 0x8 = max_value (64-bit data)
//
// One input word is accepted every cycle while no NUL byte waits on a full
// parse stage; non-NUL bytes produce no output. A NUL byte yields its result
// word through the parse, sign and bound stages, each with its own valid bit.
// Synchronous reset clears the parse state and sets the bounds to the full
// signed 64-bit range. A stalled output holds only its own stage; the
// earlier stages keep taking words until they are full.
// ----------------------------------------------------------------------------
module decimal_string_to_int_range_check_unit import dsti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [CH_WIDTH-1:0]       s_tdata,   // [7:0] ch
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [VALUE_WIDTH-1:0]    m_tdata,   // [63:0] value
  output logic [0:0]                m_tuser,   // [0] ok
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  logic [VALUE_WIDTH-1:0] min_value;
  logic [VALUE_WIDTH-1:0] max_value;
  dsti_end_t              end_word;
  logic                   end_valid;
  logic                   end_ready;
  dsti_fin_t              fin_word;
  logic                   fin_valid;
  logic                   fin_ready;

  dsti_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_value (min_value),
    .max_value (max_value)
  );

  dsti_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .end_word  (end_word),
    .end_valid (end_valid),
    .end_ready (end_ready)
  );

  dsti_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .end_word  (end_word),
    .end_valid (end_valid),
    .end_ready (end_ready),
    .fin_word  (fin_word),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready)
  );

  dsti_bound u_bound (
    .clk       (clk),
    .rst       (rst),
    .fin_word  (fin_word),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .min_value (min_value),
    .max_value (max_value),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // A word marked ok always lies within the programmed bounds.
  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      !($signed(m_tdata) < $signed(min_value)) &&
      !($signed(max_value) < $signed(m_tdata)))
    else $error("ok result outside the bounds");

  // A rejected string always reports a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("failed result with nonzero value");

  // A sign stage word always moves on or holds while the output is stalled.
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !fin_ready |=> fin_valid && $stable(fin_word))
    else $error("sign stage word lost under stall");

endmodule
